>>> src/khp_pkg.sv
// Types and codes shared by the handle pool modules.
package khp_pkg;

	localparam logic [2:0] MODE_DONATE = 3'd0;
	localparam logic [2:0] MODE_GET    = 3'd1;
	localparam logic [2:0] MODE_SWEEP  = 3'd2;
	localparam logic [2:0] MODE_CLOSE  = 3'd3;
	localparam logic [2:0] MODE_END    = 3'd4;

	localparam logic [2:0] EV_CLOSE   = 3'd0;
	localparam logic [2:0] EV_TRIM    = 3'd1;
	localparam logic [2:0] EV_DUP     = 3'd2;
	localparam logic [2:0] EV_TIMEOUT = 3'd3;
	localparam logic [2:0] EV_HANDED  = 3'd4;
	localparam logic [2:0] EV_NONE    = 3'd5;
	localparam logic [2:0] EV_ACCEPT  = 3'd6;
	localparam logic [2:0] EV_DONE    = 3'd7;

	localparam logic [1:0] REG_MAX_TOTAL   = 2'd0;
	localparam logic [1:0] REG_MAX_PER_KEY = 2'd1;
	localparam logic [1:0] REG_POOL_ENABLE = 2'd2;

	localparam logic [5:0] MAX_TOTAL_RST   = 6'd16;
	localparam logic [5:0] MAX_PER_KEY_RST = 6'd10;

	typedef struct packed {
		logic [2:0]  mode;
		logic [15:0] key;
		logic [15:0] handle;
		logic [15:0] lifetime;
		logic [15:0] db_number;
		logic [7:0]  flags;
		logic        no_local;
		logic [31:0] now;
	} in_word_t;

	typedef struct packed {
		logic [2:0]  event_code;
		logic [15:0] out_handle;
		logic [15:0] out_key;
		logic [15:0] out_db_number;
		logic [7:0]  out_flags;
		logic [15:0] ttl;
		logic        last;
	} out_word_t;

	typedef struct packed {
		logic [15:0] key;
		logic [15:0] handle;
		logic [15:0] timeout;
		logic [31:0] donated_at;
		logic [15:0] db_number;
		logic [7:0]  flags;
	} entry_t;

	typedef struct packed {
		logic load;
		logic shift;
	} cell_ctl_t;

	typedef enum logic [3:0] {
		ST_IDLE, ST_BYPASS, ST_COUNT, ST_DUP, ST_FULL, ST_APPEND, ST_TRIM,
		ST_ACCEPT, ST_GET, ST_MISS, ST_SWEEP, ST_CLOSE, ST_DONE
	} state_t;

endpackage

>>> src/khp_cell.sv
// One pool entry: loads a new entry or takes its upper neighbour's entry.
module khp_cell
	import khp_pkg::*;
(
	input  logic      clk,
	input  cell_ctl_t ctl,
	input  entry_t    new_entry,
	input  entry_t    upper,
	output entry_t    entry
);

	entry_t entry_q;

	always_ff @(posedge clk) begin
		if (ctl.shift) begin
			entry_q <= upper;
		end else if (ctl.load) begin
			entry_q <= new_entry;
		end
	end

	assign entry = entry_q;

endmodule

>>> src/keyed_handle_pool_lru.sv
// Keyed handle pool with oldest-first eviction, built as a shifting row of entry cells.
//
// Entries live in a row of POOL_DEPTH cells, oldest in cell 0; removing an entry shifts every
// cell above it down one place together. A sequencer walks the row one cell per cycle through
// a read mux, held only while a result word waits on a stalled output; a step that releases an
// entry also issues its result word. After a request is accepted: a bypassed donate issues its
// word directly; sweep walks the entries, close all and end release them, and each then issues
// a done word; get walks down from the newest cell to the entry handed out, or on to a miss
// word (issued directly when disabled or empty); donate counts the key over the pool, walks the
// oldest entries again for duplicates, then does the full check, the append and each trim, and
// issues the accepted word. One request is processed at a time; results leave through an output
// register so a stalled result only holds the sequencer when another result is due.
module keyed_handle_pool_lru
	import khp_pkg::*;
#(
	parameter int POOL_DEPTH = 32
) (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      in_valid,
	output logic      in_stall,
	input  in_word_t  in_word,
	output logic      out_valid,
	input  logic      out_stall,
	output out_word_t out_word,
	input  logic      cfg_we,
	input  logic [1:0] cfg_index,
	input  logic [5:0] cfg_data
);

	localparam int IW = $clog2(POOL_DEPTH);
	localparam int CW = $clog2(POOL_DEPTH + 1);
	localparam logic [CW-1:0] DEPTH_C = CW'(POOL_DEPTH);

	logic [5:0] max_total_q, max_per_key_q;
	logic       enable_q;

	state_t          state_q, state_d;
	logic [CW-1:0]   count_q, count_d, idx_q, idx_d, kcnt_q, kcnt_d;
	in_word_t        req_q;
	out_word_t       out_q, emit_word;
	logic            ov_q, emit;
	logic            rm_en, app_en;
	logic [IW-1:0]   rm_idx, rd_idx;
	logic            out_free;

	entry_t          cells [POOL_DEPTH];
	entry_t          new_entry, sel;
	logic            match, expired;
	logic signed [33:0] t;
	logic [15:0]     ttl_c;
	logic [CW-1:0]   lim;
	logic [7:0]      kneed;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			max_total_q   <= MAX_TOTAL_RST;
			max_per_key_q <= MAX_PER_KEY_RST;
			enable_q      <= 1'b1;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_MAX_TOTAL:   max_total_q   <= cfg_data;
				REG_MAX_PER_KEY: max_per_key_q <= cfg_data;
				REG_POOL_ENABLE: enable_q      <= cfg_data[0];
				default: ;
			endcase
		end
	end

	assign new_entry = '{key: req_q.key, handle: req_q.handle, timeout: req_q.lifetime,
		donated_at: req_q.now, db_number: req_q.db_number, flags: req_q.flags};

	for (genvar j = 0; j < POOL_DEPTH; j++) begin : g_cell
		cell_ctl_t ctl;
		entry_t    upper;
		assign ctl.shift = rm_en && (IW'(j) >= rm_idx);
		assign ctl.load  = app_en && (CW'(j) == count_q);
		if (j == POOL_DEPTH - 1) begin : g_top
			assign upper = cells[j];
		end else begin : g_mid
			assign upper = cells[j+1];
		end
		khp_cell u_cell (
			.clk       (clk),
			.ctl       (ctl),
			.new_entry (new_entry),
			.upper     (upper),
			.entry     (cells[j])
		);
	end

	assign sel   = cells[rd_idx];
	assign match = sel.key == req_q.key;
	assign t = $signed({18'b0, sel.timeout})
		- ($signed({2'b0, req_q.now}) - $signed({2'b0, sel.donated_at}));
	assign expired = (sel.timeout != 16'd0) && (t <= 34'sd0);
	assign ttl_c = (t < 34'sd0) ? 16'd0 : (t > 34'sd65535) ? 16'hFFFF : t[15:0];

	assign lim = ((max_total_q == 6'd0) || ({1'b0, max_total_q} > 7'(POOL_DEPTH)))
		? DEPTH_C : CW'(max_total_q);
	assign kneed = 8'(kcnt_q) + 8'd1;

	assign out_free = !ov_q || !out_stall;

	function automatic out_word_t slot_word(logic [2:0] code, entry_t e, logic [15:0] ttl_v,
		logic last_v);
		out_word_t w;
		w.event_code    = code;
		w.out_handle    = e.handle;
		w.out_key       = e.key;
		w.out_db_number = e.db_number;
		w.out_flags     = e.flags;
		w.ttl           = ttl_v;
		w.last          = last_v;
		return w;
	endfunction

	always_comb begin
		state_d   = state_q;
		count_d   = count_q;
		idx_d     = idx_q;
		kcnt_d    = kcnt_q;
		rm_en     = 1'b0;
		app_en    = 1'b0;
		rm_idx    = '0;
		rd_idx    = idx_q[IW-1:0];
		emit      = 1'b0;
		emit_word = slot_word(EV_CLOSE, sel, ttl_c, 1'b0);
		case (state_q)
			ST_IDLE: begin
				if (in_valid) begin
					idx_d  = '0;
					kcnt_d = '0;
					case (in_word.mode)
						MODE_DONATE: state_d = (!enable_q || in_word.no_local) ? ST_BYPASS
							: ST_COUNT;
						MODE_GET: begin
							idx_d   = count_q;
							state_d = (enable_q && count_q != '0) ? ST_GET : ST_MISS;
						end
						MODE_SWEEP: state_d = ST_SWEEP;
						MODE_CLOSE, MODE_END: state_d = ST_CLOSE;
						default: state_d = ST_IDLE;
					endcase
				end
			end
			ST_BYPASS: begin
				if (out_free) begin
					emit      = 1'b1;
					emit_word = slot_word(EV_CLOSE, new_entry, req_q.lifetime, 1'b1);
					state_d   = ST_IDLE;
				end
			end
			ST_COUNT: begin
				if (idx_q == count_q) begin
					idx_d   = '0;
					state_d = ST_DUP;
				end else begin
					if (match) kcnt_d = kcnt_q + 1'b1;
					idx_d = idx_q + 1'b1;
				end
			end
			ST_DUP: begin
				if (max_per_key_q == 6'd0 || kneed <= {2'b0, max_per_key_q}
						|| idx_q == count_q) begin
					state_d = ST_FULL;
				end else if (!match) begin
					idx_d = idx_q + 1'b1;
				end else if (out_free) begin
					emit      = 1'b1;
					emit_word = slot_word(EV_DUP, sel, ttl_c, 1'b0);
					rm_en     = 1'b1;
					rm_idx    = idx_q[IW-1:0];
					count_d   = count_q - 1'b1;
					kcnt_d    = kcnt_q - 1'b1;
				end
			end
			ST_FULL: begin
				rd_idx = '0;
				if (count_q < DEPTH_C) begin
					state_d = ST_APPEND;
				end else if (out_free) begin
					emit      = 1'b1;
					emit_word = slot_word(EV_TRIM, sel, ttl_c, 1'b0);
					rm_en     = 1'b1;
					count_d   = count_q - 1'b1;
					state_d   = ST_APPEND;
				end
			end
			ST_APPEND: begin
				app_en  = 1'b1;
				count_d = count_q + 1'b1;
				state_d = ST_TRIM;
			end
			ST_TRIM: begin
				rd_idx = '0;
				if (count_q <= lim) begin
					state_d = ST_ACCEPT;
				end else if (out_free) begin
					emit      = 1'b1;
					emit_word = slot_word(EV_TRIM, sel, ttl_c, 1'b0);
					rm_en     = 1'b1;
					count_d   = count_q - 1'b1;
				end
			end
			ST_ACCEPT: begin
				if (out_free) begin
					emit      = 1'b1;
					emit_word = slot_word(EV_ACCEPT, new_entry, req_q.lifetime, 1'b1);
					state_d   = ST_IDLE;
				end
			end
			ST_GET: begin
				rd_idx = IW'(idx_q - 1'b1);
				if (idx_q == '0) begin
					state_d = ST_MISS;
				end else if (!match) begin
					idx_d = idx_q - 1'b1;
				end else if (out_free) begin
					emit    = 1'b1;
					rm_en   = 1'b1;
					rm_idx  = rd_idx;
					count_d = count_q - 1'b1;
					idx_d   = idx_q - 1'b1;
					if (expired) begin
						emit_word = slot_word(EV_TIMEOUT, sel, ttl_c, 1'b0);
					end else begin
						emit_word = slot_word(EV_HANDED, sel, ttl_c, 1'b1);
						state_d   = ST_IDLE;
					end
				end
			end
			ST_MISS: begin
				if (out_free) begin
					emit              = 1'b1;
					emit_word         = '0;
					emit_word.event_code = EV_NONE;
					emit_word.out_key = req_q.key;
					emit_word.last    = 1'b1;
					state_d           = ST_IDLE;
				end
			end
			ST_SWEEP: begin
				if (idx_q == count_q) begin
					state_d = ST_DONE;
				end else if (!expired) begin
					idx_d = idx_q + 1'b1;
				end else if (out_free) begin
					emit      = 1'b1;
					emit_word = slot_word(EV_TIMEOUT, sel, ttl_c, 1'b0);
					rm_en     = 1'b1;
					rm_idx    = idx_q[IW-1:0];
					count_d   = count_q - 1'b1;
				end
			end
			ST_CLOSE: begin
				rd_idx = '0;
				if (count_q == '0) begin
					state_d = ST_DONE;
				end else if (out_free) begin
					emit      = 1'b1;
					emit_word = slot_word(EV_CLOSE, sel, ttl_c, 1'b0);
					rm_en     = 1'b1;
					count_d   = count_q - 1'b1;
				end
			end
			ST_DONE: begin
				if (out_free) begin
					emit                 = 1'b1;
					emit_word            = '0;
					emit_word.event_code = EV_DONE;
					emit_word.last       = 1'b1;
					state_d              = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			count_q <= '0;
			idx_q   <= '0;
			kcnt_q  <= '0;
			ov_q    <= 1'b0;
		end else begin
			state_q <= state_d;
			count_q <= count_d;
			idx_q   <= idx_d;
			kcnt_q  <= kcnt_d;
			if (emit) begin
				ov_q <= 1'b1;
			end else if (!out_stall) begin
				ov_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == ST_IDLE && in_valid) begin
			req_q <= in_word;
		end
		if (emit) begin
			out_q <= emit_word;
		end
	end

	assign in_stall  = state_q != ST_IDLE;
	assign out_valid = ov_q;
	assign out_word  = out_q;

	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= DEPTH_C) else $error("entry count above pool depth");

	a_emit_free: assert property (@(posedge clk) disable iff (!arst_n)
		emit |-> out_free) else $error("result issued over a held word");

	a_scan_bound: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_SWEEP || state_q == ST_COUNT || state_q == ST_DUP) |-> idx_q <= count_q)
		else $error("scan index beyond filled cells");

	a_count_step: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_IDLE) |=> ($past(count_q) == count_q))
		else $error("pool changed while idle");

endmodule

>>> tb/sv/keyed_handle_pool_lru_chk.sv
// Checker for the keyed handle pool: predicts result words and compares them.
module keyed_handle_pool_lru_chk
	import khp_pkg::*;
#(
	parameter int POOL_DEPTH = 32
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	input  logic       in_stall,
	input  in_word_t   in_word,
	input  logic       out_valid,
	input  logic       out_stall,
	input  out_word_t  out_word,
	input  logic       cfg_we,
	input  logic [1:0] cfg_index,
	input  logic [5:0] cfg_data,
	output int         fail_count,
	output int         pending
);
	timeunit 1ns;
	timeprecision 1ps;

	logic [5:0] lim_total;
	logic [5:0] lim_per_key;
	logic       enabled;
	entry_t     pool[$];
	out_word_t  expected_words[$];

	function automatic logic [15:0] remaining(entry_t e, logic [31:0] now);
		longint t;
		t = longint'(e.timeout) - (longint'(now) - longint'(e.donated_at));
		if (t < 0)
			return 16'd0;
		if (t > 65535)
			return 16'hFFFF;
		return t[15:0];
	endfunction

	function automatic bit expired(entry_t e, logic [31:0] now);
		return e.timeout != 0 && longint'(now) >= longint'(e.donated_at) + longint'(e.timeout);
	endfunction

	function automatic out_word_t mk(logic [2:0] c, logic [15:0] h, logic [15:0] k,
		logic [15:0] db, logic [7:0] fl, logic [15:0] ttl);
		out_word_t w;
		w.event_code = c;
		w.out_handle = h;
		w.out_key = k;
		w.out_db_number = db;
		w.out_flags = fl;
		w.ttl = ttl;
		w.last = 1'b0;
		return w;
	endfunction

	function automatic out_word_t release_word(logic [2:0] c, entry_t e, logic [31:0] now);
		return mk(c, e.handle, e.key, e.db_number, e.flags, remaining(e, now));
	endfunction

	task automatic predict_pool(in_word_t w);
		out_word_t res[$];
		entry_t    e;
		int        cnt, lim, i;
		bit        got;
		if (w.mode == MODE_DONATE) begin
			if (!enabled || w.no_local) begin
				res.push_back(mk(EV_CLOSE, w.handle, w.key, w.db_number, w.flags,
					w.lifetime));
			end else begin
				forever begin
					cnt = 0;
					foreach (pool[j])
						if (pool[j].key == w.key)
							cnt++;
					if (lim_per_key == 0 || cnt + 1 <= lim_per_key)
						break;
					for (i = 0; pool[i].key != w.key; i++);
					res.push_back(release_word(EV_DUP, pool[i], w.now));
					pool.delete(i);
				end
				if (pool.size() >= POOL_DEPTH) begin
					res.push_back(release_word(EV_TRIM, pool[0], w.now));
					pool.delete(0);
				end
				e.key = w.key;
				e.handle = w.handle;
				e.timeout = w.lifetime;
				e.donated_at = w.now;
				e.db_number = w.db_number;
				e.flags = w.flags;
				pool.push_back(e);
				lim = (lim_total == 0 || lim_total > POOL_DEPTH) ? POOL_DEPTH : lim_total;
				while (pool.size() > lim) begin
					res.push_back(release_word(EV_TRIM, pool[0], w.now));
					pool.delete(0);
				end
				res.push_back(mk(EV_ACCEPT, w.handle, w.key, w.db_number, w.flags,
					w.lifetime));
			end
		end else if (w.mode == MODE_GET) begin
			got = 0;
			if (enabled) begin
				i = pool.size();
				while (!got && i > 0) begin
					i--;
					if (pool[i].key == w.key) begin
						if (expired(pool[i], w.now)) begin
							res.push_back(release_word(EV_TIMEOUT, pool[i], w.now));
						end else begin
							res.push_back(release_word(EV_HANDED, pool[i], w.now));
							got = 1;
						end
						pool.delete(i);
					end
				end
			end
			if (!got)
				res.push_back(mk(EV_NONE, 0, w.key, 0, 0, 0));
		end else if (w.mode == MODE_SWEEP) begin
			i = 0;
			while (i < pool.size()) begin
				if (expired(pool[i], w.now)) begin
					res.push_back(release_word(EV_TIMEOUT, pool[i], w.now));
					pool.delete(i);
				end else begin
					i++;
				end
			end
			res.push_back(mk(EV_DONE, 0, 0, 0, 0, 0));
		end else if (w.mode == MODE_CLOSE || w.mode == MODE_END) begin
			while (pool.size() > 0) begin
				res.push_back(release_word(EV_CLOSE, pool[0], w.now));
				pool.delete(0);
			end
			res.push_back(mk(EV_DONE, 0, 0, 0, 0, 0));
		end
		if (res.size() > 0) begin
			res[res.size()-1].last = 1'b1;
			foreach (res[j])
				expected_words.push_back(res[j]);
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		out_word_t x;
		if (!arst_n) begin
			lim_total <= MAX_TOTAL_RST;
			lim_per_key <= MAX_PER_KEY_RST;
			enabled <= 1'b1;
			pool.delete();
			expected_words.delete();
			fail_count <= 0;
		end else begin
			if (cfg_we) begin
				case (cfg_index)
				REG_MAX_TOTAL: begin
					lim_total <= cfg_data;
				end
				REG_MAX_PER_KEY: begin
					lim_per_key <= cfg_data;
				end
				REG_POOL_ENABLE: begin
					enabled <= cfg_data[0];
				end
				default: ;
				endcase
			end
			if (in_valid && !in_stall)
				predict_pool(in_word);
			if (out_valid && !out_stall) begin
				if (expected_words.size() == 0) begin
					if (fail_count < 10)
						$display("unexpected word %h", out_word);
					fail_count <= fail_count + 1;
				end else begin
					x = expected_words.pop_front();
					if (x !== out_word) begin
						if (fail_count < 10)
							$display("mismatch: expected %h actual %h", x, out_word);
						fail_count <= fail_count + 1;
					end
				end
			end
		end
	end

	assign pending = expected_words.size();
endmodule

>>> tb/sv/keyed_handle_pool_lru_tb.sv
// Testbench top for the keyed handle pool: stimulus, configuration phases, verdict.
module keyed_handle_pool_lru_tb
	import khp_pkg::*;
();
	timeunit 1ns;
	timeprecision 1ps;

	logic       clk = 0;
	logic       arst_n = 0;
	logic       in_valid = 0;
	logic       in_stall;
	in_word_t   in_word = '0;
	logic       out_valid;
	logic       out_stall = 0;
	out_word_t  out_word;
	logic       cfg_we = 0;
	logic [1:0] cfg_index = '0;
	logic [5:0] cfg_data = '0;
	int         fail_count;
	int         pending;
	bit         quiet = 0;
	bit         hold_off = 0;
	logic [31:0] clock_now = 32'd1000;

	always #10 clk = ~clk;

	keyed_handle_pool_lru i_dut (.*);

	keyed_handle_pool_lru_chk i_chk (.*);

	// receiver: random stall bursts, plus one long hold-off
	initial begin
		int n;
		forever begin
			@(posedge clk);
			if (hold_off) begin
				out_stall <= 1'b1;
				repeat (300) @(posedge clk);
				out_stall <= 1'b0;
				hold_off = 0;
			end else if (!quiet && $urandom_range(0, 5) == 0) begin
				n = $urandom_range(1, 3);
				out_stall <= 1'b1;
				repeat (n - 1) @(posedge clk);
				@(posedge clk);
				out_stall <= 1'b0;
			end
		end
	end

	task automatic send_word(in_word_t w);
		int n;
		if (!quiet && $urandom_range(0, 4) == 0) begin
			n = $urandom_range(1, 3);
			in_valid <= 1'b0;
			repeat (n) @(posedge clk);
		end
		in_valid <= 1'b1;
		in_word <= w;
		do @(posedge clk); while (in_stall);
	endtask

	task automatic put_word(logic [2:0] m, logic [15:0] k, logic [15:0] h,
		logic [15:0] t, logic [31:0] now);
		in_word_t w;
		w.mode = m;
		w.key = k;
		w.handle = h;
		w.lifetime = t;
		w.db_number = 16'($urandom);
		w.flags = 8'($urandom);
		w.no_local = 1'b0;
		w.now = now;
		send_word(w);
	endtask

	task automatic write_reg(logic [1:0] idx, logic [5:0] val);
		in_valid <= 1'b0;
		while (pending != 0)
			@(posedge clk);
		repeat (100) @(posedge clk);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		@(posedge clk);
		cfg_we <= 1'b0;
	endtask

	task automatic random_word(int nkeys);
		in_word_t w;
		int r;
		r = $urandom_range(0, 99);
		w = in_word_t'({$urandom, $urandom, $urandom});
		w.key = (nkeys > 0) ? 16'($urandom_range(0, nkeys - 1)) : 16'($urandom);
		if ($urandom_range(0, 3) == 0)
			w.key = 16'hFFFF - w.key;
		w.no_local = ($urandom_range(0, 15) == 0);
		w.lifetime = ($urandom_range(0, 3) == 0) ? 16'd0 :
			($urandom_range(0, 7) == 0) ? 16'($urandom) : 16'($urandom_range(1, 40));
		clock_now = clock_now + $urandom_range(0, 6);
		w.now = ($urandom_range(0, 40) == 0) ? $urandom : clock_now;
		if (r < 55)
			w.mode = MODE_DONATE;
		else if (r < 82)
			w.mode = MODE_GET;
		else if (r < 92)
			w.mode = MODE_SWEEP;
		else if (r < 95)
			w.mode = MODE_CLOSE;
		else if (r < 97)
			w.mode = MODE_END;
		else
			w.mode = 3'($urandom_range(5, 7));
		send_word(w);
	endtask

	initial begin
		in_word_t w;
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed: field extremes, every mode, bypass, miss, expiry, time backwards
		put_word(MODE_DONATE, 16'h0000, 16'h0000, 16'h0000, 32'h0);
		put_word(MODE_DONATE, 16'hFFFF, 16'hFFFF, 16'hFFFF, 32'hFFFF_FFFF);
		put_word(MODE_GET, 16'hFFFF, 0, 0, 32'h0);
		put_word(MODE_GET, 16'h1234, 0, 0, 32'h10);
		put_word(MODE_DONATE, 16'h5, 16'h11, 16'd5, 32'd100);
		put_word(MODE_DONATE, 16'h5, 16'h12, 16'd50, 32'd100);
		put_word(MODE_GET, 16'h5, 0, 0, 32'd200);
		put_word(MODE_DONATE, 16'h6, 16'h13, 16'd3, 32'd100);
		put_word(MODE_SWEEP, 0, 0, 0, 32'd103);
		w = '1;
		w.mode = MODE_DONATE;
		send_word(w);
		put_word(MODE_CLOSE, 0, 0, 0, 32'd300);
		put_word(MODE_END, 0, 0, 0, 32'd300);
		put_word(3'd7, 0, 0, 0, 32'd0);
		put_word(MODE_GET, 16'h0, 0, 0, 32'd0);
		// per key duplicates
		repeat (12) put_word(MODE_DONATE, 16'h9, 16'($urandom), 16'd0, 32'd400);
		put_word(MODE_END, 0, 0, 0, 32'd400);

		write_reg(REG_MAX_TOTAL, 6'd0);
		write_reg(REG_MAX_PER_KEY, 6'd0);
		repeat (34) put_word(MODE_DONATE, 16'($urandom_range(0, 2)), 16'($urandom),
			16'd0, 32'd500);
		write_reg(REG_POOL_ENABLE, 6'd0);
		put_word(MODE_DONATE, 16'h1, 16'h1, 16'h1, 32'd1);
		put_word(MODE_GET, 16'h1, 0, 0, 32'd1);
		write_reg(REG_POOL_ENABLE, 6'd1);
		put_word(MODE_CLOSE, 0, 0, 0, 32'd600);

		// long receiver hold-off while donations pile up
		write_reg(REG_MAX_TOTAL, 6'd32);
		hold_off = 1;
		repeat (40) random_word(4);

		for (int ph = 0; ph < 6; ph++) begin
			write_reg(REG_MAX_TOTAL, 6'($urandom_range(0, 63)));
			write_reg(REG_MAX_PER_KEY, (ph == 1) ? 6'd63 : 6'($urandom_range(0, 6)));
			write_reg(REG_POOL_ENABLE, ($urandom_range(0, 4) != 0) ? 6'd1 : 6'h3E);
			if (ph == 5)
				quiet = 1;
			repeat (50) random_word((ph == 2) ? 0 : 6);
		end
		write_reg(REG_MAX_TOTAL, 6'd1);
		write_reg(REG_MAX_PER_KEY, 6'd1);
		repeat (20) random_word(3);
		in_valid <= 1'b0;

		while (pending != 0)
			@(posedge clk);
		repeat (100) @(posedge clk);
		if (fail_count == 0)
			$display("SUCCESS");
		else
			$display("FAILURE");
		$finish;
	end

	initial begin
		#(20ns * 1000000);
		$display("FAILURE");
		$finish;
	end
endmodule
